### hdl/date_span_day_counter_defines.svh
// Assertion macros for the date span day counter RTL.
`ifndef DATE_SPAN_DAY_COUNTER_DEFINES_SVH
`define DATE_SPAN_DAY_COUNTER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define DSDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define DSDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dsdc_pkg.sv
// Package with widths, calendar constants and tables for the day counter.
`default_nettype none

package dsdc_pkg;

    localparam int YEAR_W   = 13;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 21;
    localparam int COUNT_W  = 21;
    localparam int QUOT_W   = 6;
    localparam int PROD_W   = 25;

    localparam logic [YEAR_W-1:0]   YEAR_MAX      = 13'd5000;
    localparam logic [MONTH_W-1:0]  MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_MAX     = 4'd12;
    localparam logic [MONTH_W-1:0]  MONTH_SHIFT   = 4'd3;
    localparam logic [MONTH_W-1:0]  MONTH_WRAP    = 4'd9;
    localparam logic [DAY_W-1:0]    FEB_LEAP_DAYS = 5'd29;
    localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 21'd365;
    localparam logic [YEAR_W-1:0]   CENTURY       = 13'd100;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam logic [PROD_W-1:0]   RECIP_100     = 25'd5243;
    localparam int                  RECIP_SHIFT   = 19;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic                ok;
    } dsdc_date_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // Days before the given month in a year that starts on March 1.
    function automatic logic [8:0] month_off(input logic [MONTH_W-1:0] mi);
        logic [8:0] n;
        unique case (mi)
            4'd0:    n = 9'd0;
            4'd1:    n = 9'd31;
            4'd2:    n = 9'd61;
            4'd3:    n = 9'd92;
            4'd4:    n = 9'd122;
            4'd5:    n = 9'd153;
            4'd6:    n = 9'd184;
            4'd7:    n = 9'd214;
            4'd8:    n = 9'd245;
            4'd9:    n = 9'd275;
            4'd10:   n = 9'd306;
            4'd11:   n = 9'd337;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/dsdc_date_path.sv
// Two-stage serial day number and validity check for one calendar date.
`default_nettype none

module dsdc_date_path
    import dsdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [YEAR_W-1:0]  year,
    input  wire logic [MONTH_W-1:0] month,
    input  wire logic [DAY_W-1:0]   day,
    output dsdc_date_t              date_res
);

    // stage 1: shift the year start to March, divide years by 100
    logic [YEAR_W-1:0]  yy_next;
    logic [MONTH_W-1:0] mi_next;
    logic [PROD_W-1:0]  prod_y;
    logic [PROD_W-1:0]  prod_yy;
    logic               range_ok_next;

    logic [YEAR_W-1:0]  y_reg;
    logic [YEAR_W-1:0]  yy_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [MONTH_W-1:0] mi_reg;
    logic [DAY_W-1:0]   d_reg;
    logic [QUOT_W-1:0]  q_y_reg;
    logic [QUOT_W-1:0]  q_yy_reg;
    logic               range_ok_reg;

    always_comb
    begin
        if (month <= MONTH_FEB)
        begin
            yy_next = year - YEAR_W'(1);
            mi_next = month + MONTH_WRAP;
        end
        else
        begin
            yy_next = year;
            mi_next = month - MONTH_SHIFT;
        end
        prod_y  = PROD_W'(year) * RECIP_100;
        prod_yy = PROD_W'(yy_next) * RECIP_100;
        range_ok_next = (year != '0) && (year <= YEAR_MAX) && (month != '0)
                     && (month <= MONTH_MAX) && (day != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg        <= year;
            yy_reg       <= yy_next;
            m_reg        <= month;
            mi_reg       <= mi_next;
            d_reg        <= day;
            q_y_reg      <= prod_y[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
            q_yy_reg     <= prod_yy[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
            range_ok_reg <= range_ok_next;
        end
    end

    // stage 2: leap rule, month length, serial day number
    logic               leap;
    logic [DAY_W-1:0]   mlen;
    dsdc_date_t         res_next;
    dsdc_date_t         res_reg;

    always_comb
    begin
        // a century year is leap only when its century count is a multiple of 4
        leap = (y_reg[1:0] == 2'b00)
            && ((y_reg != YEAR_W'(q_y_reg) * CENTURY) || (q_y_reg[1:0] == 2'b00));
        mlen = (m_reg == MONTH_FEB && leap) ? FEB_LEAP_DAYS : month_len(m_reg);
        res_next.ok     = range_ok_reg && (d_reg <= mlen);
        res_next.serial = SERIAL_W'(yy_reg) * DAYS_PER_YEAR
                        + SERIAL_W'(yy_reg[YEAR_W-1:2])
                        - SERIAL_W'(q_yy_reg)
                        + SERIAL_W'(q_yy_reg[QUOT_W-1:2])
                        + SERIAL_W'(month_off(mi_reg))
                        + SERIAL_W'(d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign date_res = res_reg;

endmodule

`default_nettype wire

### hdl/date_span_day_counter.sv
// Top level: days between two Gregorian dates, three-stage pipeline.
`default_nettype none

// Counts the days from a start date to an end date (years 1..5000) and adds
// one when include_end is set; when the start is not earlier, only that
// added one remains. A date with a month, day or year out of range, or a day
// past the end of its month, sets date_invalid and forces the count to zero.
// The block takes one transaction per clock unless a held result stalls the
// output. Two stages build each date's serial day number (year division by
// 100, then the multiply-add), and one stage compares and subtracts. A stall
// on the output holds every stage; nothing is dropped or repeated.

`include "date_span_day_counter_defines.svh"

module date_span_day_counter
    import dsdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [YEAR_W-1:0]  start_year,
    input  wire logic [MONTH_W-1:0] start_month,
    input  wire logic [DAY_W-1:0]   start_day,
    input  wire logic [YEAR_W-1:0]  end_year,
    input  wire logic [MONTH_W-1:0] end_month,
    input  wire logic [DAY_W-1:0]   end_day,
    input  wire logic               include_end,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [COUNT_W-1:0] day_count,
    output      logic               date_invalid
);

    logic               en;
    logic               v1_reg;
    logic               v2_reg;
    logic               out_valid_reg;
    logic               inc1_reg;
    logic               inc2_reg;
    logic [COUNT_W-1:0] day_count_reg;
    logic               date_invalid_reg;
    logic [COUNT_W-1:0] day_count_next;
    logic               date_invalid_next;
    dsdc_date_t         start_res;
    dsdc_date_t         end_res;

    // advance the whole pipe unless a finished result is held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    dsdc_date_path u_start (
        .clk      (clk),
        .en       (en),
        .year     (start_year),
        .month    (start_month),
        .day      (start_day),
        .date_res (start_res)
    );

    dsdc_date_path u_end (
        .clk      (clk),
        .en       (en),
        .year     (end_year),
        .month    (end_month),
        .day      (end_day),
        .date_res (end_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_comb
    begin
        if (!start_res.ok || !end_res.ok)
        begin
            day_count_next    = '0;
            date_invalid_next = 1'b1;
        end
        else
        begin
            date_invalid_next = 1'b0;
            if (end_res.serial > start_res.serial)
            begin
                day_count_next = COUNT_W'(end_res.serial - start_res.serial)
                               + COUNT_W'(inc2_reg);
            end
            else
            begin
                day_count_next = COUNT_W'(inc2_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inc1_reg         <= include_end;
            inc2_reg         <= inc1_reg;
            day_count_reg    <= day_count_next;
            date_invalid_reg <= date_invalid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign day_count    = day_count_reg;
    assign date_invalid = date_invalid_reg;

    `DSDC_ASSERT_NOW(a_invalid_zero, out_valid && date_invalid, day_count == '0, "bad date count")
    `DSDC_ASSERT_NEXT(a_enter, in_valid && in_ready, v1_reg, "transaction lost at stage 1")
    `DSDC_ASSERT_NEXT(a_reach_out, v2_reg && en, out_valid, "stage 2 transaction lost")

endmodule

`default_nettype wire

### tb/sv/date_span_day_counter_tb.sv
// Self-checking testbench for the date span day counter.
module date_span_day_counter_tb;
    import dsdc_pkg::*;

    typedef struct {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic               include_end;
    } date_pair_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               invalid;
    } span_result_t;

    // Keeps the expected spans in order and compares them with what comes out.
    class span_scoreboard;
        span_result_t span_q[$];
        int unsigned  mismatches;
        int unsigned  pairs_noted;
        int unsigned  spans_checked;
        int unsigned  invalid_seen;

        function bit leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_of_month(int unsigned y, int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        function bit date_good(int unsigned y, int unsigned m, int unsigned d);
            return (y >= 1) && (y <= 5000) && (m >= 1) && (m <= 12) &&
                   (d >= 1) && (d <= days_of_month(y, m));
        endfunction

        // Day number with the year starting on March 1, so the leap day falls last.
        function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
            if (m <= 2)
            begin
                y = y - 1;
                m = m + 12;
            end
            m = m - 3;
            return 365 * y + y / 4 - y / 100 + y / 400 + (153 * m + 2) / 5 + d;
        endfunction

        function span_result_t predict_span(date_pair_t p);
            span_result_t r;
            int unsigned  a;
            int unsigned  b;
            int unsigned  n;
            r.count   = '0;
            r.invalid = 1'b0;
            if (!date_good(p.start_year, p.start_month, p.start_day) ||
                !date_good(p.end_year, p.end_month, p.end_day))
            begin
                r.invalid = 1'b1;
            end
            else
            begin
                a = day_number(p.start_year, p.start_month, p.start_day);
                b = day_number(p.end_year, p.end_month, p.end_day);
                n = (b > a) ? b - a : 0;
                n = n + p.include_end;
                r.count = n[COUNT_W-1:0];
            end
            return r;
        endfunction

        function void note_pair(date_pair_t p);
            span_q.push_back(predict_span(p));
            pairs_noted++;
        endfunction

        function void check_span(logic [COUNT_W-1:0] count, logic invalid);
            span_result_t want;
            if (span_q.size() == 0)
            begin
                $error("unexpected result: day_count=%0d date_invalid=%0b", count, invalid);
                mismatches++;
                return;
            end
            want = span_q.pop_front();
            spans_checked++;
            if (want.invalid)
                invalid_seen++;
            if (count !== want.count)
            begin
                $error("day_count: expected %0d, actual %0d", want.count, count);
                mismatches++;
            end
            if (invalid !== want.invalid)
            begin
                $error("date_invalid: expected %0b, actual %0b", want.invalid, invalid);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return span_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               include_end;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] day_count;
    logic               date_invalid;

    span_scoreboard board;
    bit             no_idle;

    date_span_day_counter DUT (.*);

    always #6 clk = ~clk;

    initial
    begin
        #3000000;
        $display("date_span_day_counter regression: fail");
        $finish;
    end

    // Receiver: stall at random, except in the quiet window.
    always @(negedge clk)
    begin
        out_ready = (!rst_n || no_idle) ? 1'b1 : ($urandom_range(99) >= 24);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_span(day_count, date_invalid);
    end

    function automatic date_pair_t make_pair(int unsigned sy, int unsigned sm, int unsigned sd,
                                             int unsigned ey, int unsigned em, int unsigned ed,
                                             bit inc);
        date_pair_t p;
        p.start_year  = sy[YEAR_W-1:0];
        p.start_month = sm[MONTH_W-1:0];
        p.start_day   = sd[DAY_W-1:0];
        p.end_year    = ey[YEAR_W-1:0];
        p.end_month   = em[MONTH_W-1:0];
        p.end_day     = ed[DAY_W-1:0];
        p.include_end = inc;
        return p;
    endfunction

    function automatic void random_date(output int unsigned y, output int unsigned m,
                                        output int unsigned d);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
            y = 1;
        else if (pick < 6)
            y = 5000;
        else if (pick < 16)
            y = 4 * $urandom_range(1, 1250);
        else
            y = $urandom_range(1, 5000);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, board.days_of_month(y, m));
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t  p;
        int unsigned sy, sm, sd, ey, em, ed;
        int unsigned mode;
        mode = $urandom_range(99);
        random_date(sy, sm, sd);
        random_date(ey, em, ed);
        if (mode >= 70 && mode < 80)
        begin
            // close spans, often inside one year
            ey = sy + $urandom_range(0, 1);
            if (ey > 5000)
                ey = 5000;
            ed = $urandom_range(1, board.days_of_month(ey, em));
        end
        else if (mode >= 80 && mode < 88)
        begin
            // push one day just past the end of its month
            if ($urandom_range(1))
                sd = board.days_of_month(sy, sm) + 1;
            else
                ed = board.days_of_month(ey, em) + 1;
        end
        p = make_pair(sy, sm, sd, ey, em, ed, $urandom_range(1));
        if (mode >= 88)
        begin
            p.start_year  = YEAR_W'($urandom);
            p.start_month = MONTH_W'($urandom);
            p.start_day   = DAY_W'($urandom);
            p.end_year    = YEAR_W'($urandom);
            p.end_month   = MONTH_W'($urandom);
            p.end_day     = DAY_W'($urandom);
        end
        return p;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pair(date_pair_t p);
        while (!no_idle && $urandom_range(99) < 24)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        start_year  = p.start_year;
        start_month = p.start_month;
        start_day   = p.start_day;
        end_year    = p.end_year;
        end_month   = p.end_month;
        end_day     = p.end_day;
        include_end = p.include_end;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_pair(p);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        date_pair_t directed_q[$];
        clk         = 1'b0;
        board       = new();
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        start_year  = '0;
        start_month = '0;
        start_day   = '0;
        end_year    = '0;
        end_month   = '0;
        end_day     = '0;
        include_end = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_q.push_back(make_pair(2000, 1, 1, 2000, 1, 1, 0));
        directed_q.push_back(make_pair(2000, 1, 1, 2000, 1, 1, 1));
        directed_q.push_back(make_pair(1, 1, 1, 5000, 12, 31, 1));
        directed_q.push_back(make_pair(1, 1, 1, 5000, 12, 31, 0));
        directed_q.push_back(make_pair(5000, 12, 31, 1, 1, 1, 1));
        directed_q.push_back(make_pair(2000, 2, 29, 2000, 3, 1, 0));
        directed_q.push_back(make_pair(1900, 2, 29, 1900, 3, 1, 0));
        directed_q.push_back(make_pair(2004, 2, 28, 2004, 2, 29, 1));
        directed_q.push_back(make_pair(2001, 1, 1, 2001, 2, 29, 0));
        directed_q.push_back(make_pair(2400, 2, 29, 2401, 2, 28, 0));
        directed_q.push_back(make_pair(2024, 4, 1, 2024, 4, 31, 1));
        directed_q.push_back(make_pair(2024, 1, 31, 2024, 12, 31, 0));
        directed_q.push_back(make_pair(2024, 0, 1, 2024, 5, 5, 1));
        directed_q.push_back(make_pair(2024, 13, 1, 2024, 5, 5, 0));
        directed_q.push_back(make_pair(2024, 5, 5, 2024, 15, 1, 0));
        directed_q.push_back(make_pair(2024, 5, 0, 2024, 5, 5, 1));
        directed_q.push_back(make_pair(0, 5, 5, 2024, 5, 5, 0));
        directed_q.push_back(make_pair(2024, 5, 5, 5001, 1, 1, 1));
        directed_q.push_back(make_pair(8191, 15, 31, 8191, 15, 31, 1));
        directed_q.push_back(make_pair(2023, 12, 31, 2024, 1, 1, 0));
        directed_q.push_back(make_pair(2024, 2, 28, 2024, 3, 1, 1));
        directed_q.push_back(make_pair(1, 1, 1, 1, 1, 2, 0));
        directed_q.push_back(make_pair(4999, 12, 31, 5000, 1, 1, 1));
        foreach (directed_q[i])
            send_pair(directed_q[i]);
        wait_drained();

        for (int n = 0; n < 1350; n++)
        begin
            no_idle = (n >= 400) && (n < 650);
            if (n == 900)
                wait_drained();
            send_pair(random_pair());
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d date pairs and checked %0d spans, %0d of them flagged invalid",
                 board.pairs_noted, board.spans_checked, board.invalid_seen);
        $display("covered calendar extremes, leap rules, bad fields and random stalls");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("date_span_day_counter regression: pass");
        else
            $display("date_span_day_counter regression: fail");
        $finish;
    end
endmodule
